// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the rounding converter RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/drti_pkg.sv =====
// Package for the binary64 to int64 rounding converter.
// Holds beat types, mode codes and stage records; depends on nothing.
`default_nettype none
package drti_pkg;

  typedef enum logic [1:0] {
    MODE_CEIL  = 2'd0,
    MODE_FLOOR = 2'd1,
    MODE_HALF  = 2'd2,
    MODE_HALF3 = 2'd3
  } mode_e;

  typedef struct packed {
    logic [63:0] value_bits;
    logic        value_null;
  } in_beat_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic               result_null;
    logic               overflow;
  } out_beat_t;

  localparam logic [10:0] ExpBias = 11'd1023;
  localparam logic [10:0] ExpOnes = 11'h7FF;

  // Record after the decode stage.
  typedef struct packed {
    logic        neg;
    logic        spec_null;
    logic        ovf;
    logic        big;        // already integer
    logic        below_one;  // magnitude below one
    logic        small_half;
    logic        small_frac;
    logic [52:0] full;
    logic [5:0]  sh;       // right shift 1..52, or left shift 0..10
    mode_e       mode;
  } dec_t;

  // Record after the shift stage.
  typedef struct packed {
    logic        neg;
    logic        spec_null;
    logic        ovf;
    logic        bump;
    logic [62:0] mag;
  } shf_t;

endpackage
`default_nettype wire

// ===== rtl/drti_core.sv =====
// Three-stage datapath: decode, shift and round decision, add and negate.
// Depends on drti_pkg; uses assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module drti_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                adv_i,
  input  wire logic                in_valid_i,
  input  wire drti_pkg::in_beat_t  in_beat_i,
  input  wire drti_pkg::mode_e     mode_i,
  output logic                     out_valid_o,
  output drti_pkg::out_beat_t      out_beat_o
);
  import drti_pkg::*;

  logic      v1_q, v2_q, v3_q;
  dec_t      d1_d, d1_q;
  shf_t      s2_d, s2_q;
  out_beat_t o3_d, o3_q;

  // Stage 1: field decode and class.
  always_comb begin
    logic [10:0] e;
    e = in_beat_i.value_bits[62:52];
    d1_d = '0;
    d1_d.neg        = in_beat_i.value_bits[63];
    d1_d.spec_null  = in_beat_i.value_null || (e == ExpOnes);
    d1_d.ovf        = !d1_d.spec_null && (e >= ExpBias + 11'd63);
    d1_d.big        = e >= ExpBias + 11'd52;
    d1_d.below_one  = e < ExpBias;
    d1_d.small_half = e == ExpBias - 11'd1;
    d1_d.small_frac = (e != 11'd0) || (in_beat_i.value_bits[51:0] != 52'd0);
    d1_d.full       = {1'b1, in_beat_i.value_bits[51:0]};
    if (d1_d.big) begin
      d1_d.sh = 6'(e - (ExpBias + 11'd52));
    end else begin
      d1_d.sh = 6'((ExpBias + 11'd52) - e);
    end
    d1_d.mode = mode_i;
  end

  // Stage 2: shift and rounding decision.
  always_comb begin
    logic [52:0] rem_mask;
    logic [52:0] rem;
    logic [52:0] half;
    logic        has_frac;
    logic        ge_half;
    rem_mask = (53'd1 << d1_q.sh) - 53'd1;
    rem      = d1_q.full & rem_mask;
    half     = 53'd1 << (d1_q.sh - 6'd1);
    s2_d = '0;
    s2_d.neg       = d1_q.neg;
    s2_d.spec_null = d1_q.spec_null;
    s2_d.ovf       = d1_q.ovf;
    if (d1_q.big) begin
      s2_d.mag = 63'({10'd0, d1_q.full} << d1_q.sh[3:0]);
      has_frac = 1'b0;
      ge_half  = 1'b0;
    end else if (d1_q.below_one) begin
      s2_d.mag = '0;
      has_frac = d1_q.small_frac;
      ge_half  = d1_q.small_half;
    end else begin
      s2_d.mag = 63'(d1_q.full >> d1_q.sh);
      has_frac = rem != 53'd0;
      ge_half  = rem >= half;
    end
    case (d1_q.mode)
      MODE_CEIL:  s2_d.bump = has_frac && !d1_q.neg;
      MODE_FLOOR: s2_d.bump = has_frac && d1_q.neg;
      default:    s2_d.bump = ge_half;
    endcase
  end

  // Stage 3: increment, sign and null forcing.
  always_comb begin
    logic [63:0] m;
    m = {1'b0, s2_q.mag} + {63'd0, s2_q.bump};
    o3_d.result_null = s2_q.spec_null || s2_q.ovf;
    o3_d.overflow    = s2_q.ovf;
    if (o3_d.result_null) begin
      o3_d.result_value = '0;
    end else if (s2_q.neg) begin
      o3_d.result_value = -$signed(m);
    end else begin
      o3_d.result_value = $signed(m);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d1_q <= d1_d;
      s2_q <= s2_d;
      o3_q <= o3_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_beat_o  = o3_q;

  `ASSERT_IMPL(a_ovf_null, clk_i, rst_ni, v3_q && o3_q.overflow, o3_q.result_null)
  `ASSERT_IMPL(a_null_zero, clk_i, rst_ni, v3_q && o3_q.result_null,
               o3_q.result_value == 64'sd0)
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, !adv_i, $stable(o3_q) && $stable(v3_q))
endmodule
`default_nettype wire

// ===== rtl/double_round_to_int64_top.sv =====
// Top level of the binary64 to int64 rounding converter.
// Depends on drti_pkg and drti_core.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_stall_o  | in_beat_i  (drti_pkg::in_beat_t)
//   out     | output    | out_valid_o/out_stall_i| out_beat_o (drti_pkg::out_beat_t)
//   cfg     | input     | cfg_we_i               | cfg_wdata_i (rounding mode)
//
// Each beat passes through the datapath stages in order: decode, shift with rounding
// decision, then increment and negate; the 53-bit barrel shift sets stage two.
// One beat enters every cycle while the output is not stalled.
// Reset clears the valid bits and sets the mode to ceiling.
// A stall freezes the whole pipeline; a bubble in the last stage is filled
// even when stalled, so the input stalls only when the output beat waits.
`default_nettype none
module double_round_to_int64_top (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire drti_pkg::in_beat_t  in_beat_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output drti_pkg::out_beat_t      out_beat_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_wdata_i
);
  import drti_pkg::*;

  mode_e mode_q;
  logic  adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CEIL;
    end else if (cfg_we_i) begin
      mode_q <= mode_e'(cfg_wdata_i);
    end
  end

  // The pipeline moves whenever its last beat leaves or is empty.
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  drti_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (in_valid_i),
    .in_beat_i   (in_beat_i),
    .mode_i      (mode_q),
    .out_valid_o (out_valid_o),
    .out_beat_o  (out_beat_o)
  );
endmodule
`default_nettype wire

// ===== verif/double_round_to_int64_top_tb.sv =====
// Testbench for the binary64 to int64 rounding converter top level.
// Depends on drti_pkg and double_round_to_int64_top; predicts each beat itself.
`default_nettype none
module double_round_to_int64_top_tb;
  import drti_pkg::*;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus side signals; those the bench drives start with values at time zero.
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;
  logic      cfg_we = 1'b0;
  logic [1:0] cfg_wdata = '0;

  double_round_to_int64_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_beat_i(in_beat),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_beat_o(out_beat),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata)
  );

  // The testbench's own copy of the rounding mode register.
  mode_e      cur_mode = MODE_CEIL;
  out_beat_t  pending_results[$];
  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned idle_cycles = 0;
  bit          stall_on = 1'b1;
  localparam int unsigned WatchdogLimit = 2000;

  // Rounds one binary64 pattern the way the block should, using only integer
  // arithmetic on the fields of the pattern.
  function automatic out_beat_t round_to_int(input in_beat_t b, input mode_e m);
    out_beat_t  r;
    logic       neg;
    logic [10:0] ex;
    logic [51:0] frac;
    logic [63:0] full;
    logic [63:0] mag;
    logic [63:0] rem;
    int         sh;
    logic       has_frac;
    logic       ge_half;
    logic       bump;
    r = '0;
    r.result_null = 1'b1;
    neg  = b.value_bits[63];
    ex   = b.value_bits[62:52];
    frac = b.value_bits[51:0];
    full = {11'd0, 1'b1, frac};
    has_frac = 1'b0;
    ge_half = 1'b0;
    if (b.value_null || ex == ExpOnes) return r;
    if (ex >= ExpBias + 11'd63) begin
      r.overflow = 1'b1;
      return r;
    end
    if (ex >= ExpBias + 11'd52) begin
      mag = full << (ex - ExpBias - 11'd52);
    end else if (ex >= ExpBias) begin
      sh = 52 - int'(ex - ExpBias);
      rem = full & ((64'd1 << sh) - 64'd1);
      mag = full >> sh;
      has_frac = rem != 0;
      ge_half = rem >= (64'd1 << (sh - 1));
    end else begin
      // Magnitude below one, subnormals included.
      mag = '0;
      has_frac = (ex != 0) || (frac != 0);
      ge_half = ex == ExpBias - 11'd1;
    end
    case (m)
      MODE_CEIL:  bump = has_frac && !neg;
      MODE_FLOOR: bump = has_frac && neg;
      default:    bump = ge_half;
    endcase
    if (bump) mag = mag + 64'd1;
    r.result_value = neg ? -mag : mag;
    r.result_null = 1'b0;
    return r;
  endfunction

  // Receiver: stalls on its own pattern, checks every accepted beat.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", out_beat);
      end else begin
        out_beat_t want;
        want = pending_results.pop_front();
        beats_checked++;
        if (out_beat !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected val %h null %b ovf %b, got val %h null %b ovf %b",
                     want.result_value, want.result_null, want.overflow,
                     out_beat.result_value, out_beat.result_null, out_beat.overflow);
        end
      end
    end
    // A slow pattern: long free stretches, then phases of frequent stalls.
    if ($urandom_range(0, 63) == 0) stall_on <= !stall_on;
    out_stall <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b0;
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired");
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Sends one beat and records its expected result when it is accepted.
  task automatic send_value(input logic [63:0] bits, input logic is_null);
    in_valid <= 1'b1;
    in_beat  <= '{value_bits: bits, value_null: is_null};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(round_to_int('{value_bits: bits, value_null: is_null},
                                           cur_mode));
    beats_sent++;
  endtask

  task automatic go_idle(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Waits for every expected result, then lets the pipeline drain.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Mode writes only happen when the block is idle.
  task automatic set_mode(input mode_e m);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_mode = m;
  endtask

  // Builds a value near the interesting boundaries most of the time.
  function automatic logic [63:0] random_double();
    logic [63:0] v;
    logic [10:0] ex;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: ex = 11'(ExpBias + $urandom_range(0, 10) - 2);
      4, 5:       ex = 11'(ExpBias + $urandom_range(0, 64) - 1);
      6:          ex = 11'($urandom_range(0, 2));
      7:          ex = $urandom_range(0, 1) ? ExpOnes : 11'(ExpBias + 63);
      default:    ex = v[62:52];
    endcase
    v[62:52] = ex;
    // Exact halves and integers show up now and then.
    if ($urandom_range(0, 4) == 0) v[40:0] = '0;
    return v;
  endfunction

  task automatic test_directed(input mode_e m);
    logic [63:0] vals[22];
    vals = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
             64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000,
             64'h3FE0_0000_0000_0000, 64'hBFE0_0000_0000_0000,
             64'h3FF8_0000_0000_0000, 64'hC004_0000_0000_0000,
             64'h3FDF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
             64'h800F_FFFF_FFFF_FFFF, 64'h43DF_FFFF_FFFF_FFFF,
             64'hC3DF_FFFF_FFFF_FFFF, 64'h43E0_0000_0000_0000,
             64'hC3E0_0000_0000_0000, 64'h7FF0_0000_0000_0000,
             64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001,
             64'h4330_0000_0000_0001, 64'h432F_FFFF_FFFF_FFFF,
             64'h7FEF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
    set_mode(m);
    foreach (vals[i]) send_value(vals[i], 1'b0);
    // A null beat that carries a NaN pattern is still just null.
    send_value(64'h7FF8_0000_0000_0000, 1'b1);
    send_value(64'h3FF8_0000_0000_0000, 1'b1);
  endtask

  task automatic test_random(input int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && left > 0; k++) begin
        send_value(random_double(), $urandom_range(0, 15) == 0);
        left--;
      end
      if ($urandom_range(0, 2) != 0) go_idle($urandom_range(1, 5));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // The reset mode is ceiling; check it before the first write.
    test_random(30);
    test_directed(MODE_CEIL);
    test_directed(MODE_FLOOR);
    test_directed(MODE_HALF);
    test_directed(MODE_HALF3);
    for (int p = 0; p < 8; p++) begin
      set_mode(mode_e'($urandom_range(0, 3)));
      test_random(105);
    end
    drain();
    $display("sent %0d beats (%0d checked) over all four mode codes,", beats_sent,
             beats_checked);
    $display("covering specials, range limits, halves and random values.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire
